// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
// The caller supplies clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, muted while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/ebalu_pkg.sv -----
package ebalu_pkg;

	localparam int unsigned OP_W   = 4;
	localparam int unsigned WORD_W = 16;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned FLAG_W = 4;

	// flag bit positions
	localparam int unsigned FLAG_Z = 3;
	localparam int unsigned FLAG_N = 2;
	localparam int unsigned FLAG_H = 1;
	localparam int unsigned FLAG_C = 0;

	typedef enum logic [OP_W-1:0] {
		OP_ADD   = 4'd0,
		OP_ADC   = 4'd1,
		OP_SUB   = 4'd2,
		OP_SBC   = 4'd3,
		OP_AND   = 4'd4,
		OP_XOR   = 4'd5,
		OP_OR    = 4'd6,
		OP_CP    = 4'd7,
		OP_INC8  = 4'd8,
		OP_DEC8  = 4'd9,
		OP_INC16 = 4'd10,
		OP_DEC16 = 4'd11,
		OP_ADD16 = 4'd12,
		OP_SPE8  = 4'd13
	} op_t;

	typedef struct packed {
		logic [WORD_W-1:0] result;
		logic [FLAG_W-1:0] flags;
		logic              writes;
	} alu_res_t;

endpackage

// ----- rtl/eight_bit_cpu_alu_with_flags.sv -----
// ALU of an 8-bit handheld-console CPU (SM83 style). One item carries an
// operation code, two 16-bit operands and the current Z/N/H/C flags; one
// result item comes back with the value, the new flags and a write-back bit.
// 8-bit operations (add, adc, sub, sbc, and, xor, or, cp, inc8, dec8) use the
// low operand bytes and return a zero-extended byte; inc16/dec16 keep all
// flags, add16 keeps Z, and sp+e8 adds the sign-extended low byte of
// operand_b to operand_a. Compare and the unused codes 14 and 15 return zero
// with writes_result low; the unused codes also pass flags_in through.
// Timing: an item is captured in the input register at the accepting edge and
// its result is then registered in the result register once that stage is
// free; out_valid rises when the result register holds it. One item is taken
// every cycle while out_ready is high; a stall
// on the output holds both registers and drops in_ready only once both are
// full. There is no state carried from one item to the next.
`include "assert_macros.svh"

module eight_bit_cpu_alu_with_flags (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [ebalu_pkg::OP_W-1:0]      operation,
	input  logic [ebalu_pkg::WORD_W-1:0]    operand_a,
	input  logic [ebalu_pkg::WORD_W-1:0]    operand_b,
	input  logic [ebalu_pkg::FLAG_W-1:0]    flags_in,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [ebalu_pkg::WORD_W-1:0]    result,
	output logic [ebalu_pkg::FLAG_W-1:0]    flags_out,
	output logic                            writes_result
);
	import ebalu_pkg::*;

	// input register stage
	logic              valid_s1;
	logic [OP_W-1:0]   op_s1;
	logic [WORD_W-1:0] a_s1;
	logic [WORD_W-1:0] b_s1;
	logic [FLAG_W-1:0] flags_s1;

	// result register stage
	logic     valid_s2;
	alu_res_t res_s2;

	logic     s2_free;
	logic     s1_load;
	logic     s2_load;
	alu_res_t calc;

	// output stage can take a new item when empty or draining this cycle
	assign s2_free  = !valid_s2 || out_ready;
	assign s2_load  = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;
	assign s1_load  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (s2_free)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			op_s1    <= operation;
			a_s1     <= operand_a;
			b_s1     <= operand_b;
			flags_s1 <= flags_in;
		end
		if (s2_load)
			res_s2 <= calc;
	end

	// datapath
	logic [BYTE_W-1:0]   a8;
	logic [BYTE_W-1:0]   b8;
	logic                cin;
	logic                cuse;
	logic [BYTE_W:0]     sum9;
	logic [4:0]          hsum5;
	logic [BYTE_W:0]     diff9;
	logic [4:0]          hdiff5;
	logic [BYTE_W-1:0]   logic8;
	logic [BYTE_W-1:0]   inc8;
	logic [BYTE_W-1:0]   dec8;
	logic [WORD_W:0]     sum17;
	logic [12:0]         hsum13;
	logic [WORD_W-1:0]   sp_sum;
	logic [4:0]          sp_h5;
	logic [BYTE_W:0]     sp_c9;

	assign a8 = a_s1[BYTE_W-1:0];
	assign b8 = b_s1[BYTE_W-1:0];
	assign cin = flags_s1[FLAG_C];
	// carry/borrow in only for adc and sbc
	assign cuse = cin && ((op_t'(op_s1) == OP_ADC) || (op_t'(op_s1) == OP_SBC));

	assign sum9   = {1'b0, a8} + {1'b0, b8} + {{BYTE_W{1'b0}}, cuse};
	assign hsum5  = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, cuse};
	// sign bit of the widened difference is the borrow
	assign diff9  = {1'b0, a8} - {1'b0, b8} - {{BYTE_W{1'b0}}, cuse};
	assign hdiff5 = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, cuse};
	assign inc8   = a8 + 8'd1;
	assign dec8   = a8 - 8'd1;
	assign sum17  = {1'b0, a_s1} + {1'b0, b_s1};
	assign hsum13 = {1'b0, a_s1[11:0]} + {1'b0, b_s1[11:0]};
	assign sp_sum = a_s1 + {{(WORD_W-BYTE_W){b8[BYTE_W-1]}}, b8};
	assign sp_h5  = {1'b0, a_s1[3:0]} + {1'b0, b8[3:0]};
	assign sp_c9  = {1'b0, a_s1[BYTE_W-1:0]} + {1'b0, b8};

	always_comb begin
		logic8 = '0;
		calc.result = '0;
		calc.flags  = flags_s1;
		calc.writes = 1'b1;
		case (op_t'(op_s1))
			OP_ADD, OP_ADC: begin
				calc.result = {{(WORD_W-BYTE_W){1'b0}}, sum9[BYTE_W-1:0]};
				calc.flags[FLAG_Z] = (sum9[BYTE_W-1:0] == '0);
				calc.flags[FLAG_N] = 1'b0;
				calc.flags[FLAG_H] = hsum5[4];
				calc.flags[FLAG_C] = sum9[BYTE_W];
			end
			OP_SUB, OP_SBC, OP_CP: begin
				calc.result = {{(WORD_W-BYTE_W){1'b0}}, diff9[BYTE_W-1:0]};
				calc.flags[FLAG_Z] = (diff9[BYTE_W-1:0] == '0);
				calc.flags[FLAG_N] = 1'b1;
				calc.flags[FLAG_H] = hdiff5[4];
				calc.flags[FLAG_C] = diff9[BYTE_W];
				if (op_t'(op_s1) == OP_CP) begin
					calc.result = '0;
					calc.writes = 1'b0;
				end
			end
			OP_AND, OP_XOR, OP_OR: begin
				if (op_t'(op_s1) == OP_AND)
					logic8 = a8 & b8;
				else if (op_t'(op_s1) == OP_XOR)
					logic8 = a8 ^ b8;
				else
					logic8 = a8 | b8;
				calc.result = {{(WORD_W-BYTE_W){1'b0}}, logic8};
				calc.flags[FLAG_Z] = (logic8 == '0);
				calc.flags[FLAG_N] = 1'b0;
				calc.flags[FLAG_H] = (op_t'(op_s1) == OP_AND);
				calc.flags[FLAG_C] = 1'b0;
			end
			OP_INC8: begin
				calc.result = {{(WORD_W-BYTE_W){1'b0}}, inc8};
				calc.flags[FLAG_Z] = (inc8 == '0);
				calc.flags[FLAG_N] = 1'b0;
				calc.flags[FLAG_H] = (a8[3:0] == 4'hF);
			end
			OP_DEC8: begin
				calc.result = {{(WORD_W-BYTE_W){1'b0}}, dec8};
				calc.flags[FLAG_Z] = (dec8 == '0);
				calc.flags[FLAG_N] = 1'b1;
				calc.flags[FLAG_H] = (a8[3:0] == 4'h0);
			end
			OP_INC16: calc.result = a_s1 + 16'd1;
			OP_DEC16: calc.result = a_s1 - 16'd1;
			OP_ADD16: begin
				calc.result = sum17[WORD_W-1:0];
				calc.flags[FLAG_N] = 1'b0;
				calc.flags[FLAG_H] = hsum13[12];
				calc.flags[FLAG_C] = sum17[WORD_W];
			end
			OP_SPE8: begin
				calc.result = sp_sum;
				calc.flags[FLAG_Z] = 1'b0;
				calc.flags[FLAG_N] = 1'b0;
				calc.flags[FLAG_H] = sp_h5[4];
				calc.flags[FLAG_C] = sp_c9[BYTE_W];
			end
			default: begin
				// codes 14 and 15: no-op, flags pass through
				calc.result = '0;
				calc.writes = 1'b0;
			end
		endcase
	end

	assign out_valid     = valid_s2;
	assign result        = res_s2.result;
	assign flags_out     = res_s2.flags;
	assign writes_result = res_s2.writes;

	`ASSERT_CLK(a_s1_to_s2, s2_load |=> valid_s2, "item lost between stages")
	`ASSERT_CLK(a_s1_hold, valid_s1 && !s2_free |=> valid_s1 && $stable(op_s1) && $stable(a_s1), "input stage changed while stalled")
	`ASSERT_CLK(a_cp_zero, valid_s2 && !res_s2.writes |-> res_s2.result == '0, "non-written result not zero")
	`ASSERT_CLK(a_inc16_flags, s2_load && (op_t'(op_s1) == OP_INC16 || op_t'(op_s1) == OP_DEC16) |=> flags_out == $past(flags_s1), "16-bit inc/dec altered flags")
	`ASSERT_ALWAYS(a_rst_empty, !arst_n |=> !valid_s1 && !valid_s2, "stages not empty in reset")

endmodule

// ----- sim/eight_bit_cpu_alu_with_flags_tb.sv -----
`timescale 1ns / 1ps

module eight_bit_cpu_alu_with_flags_tb;
	import ebalu_pkg::*;

	localparam int RANDOM_ITEMS    = 600;
	localparam int HOLD_OFF_CYCLES = 60;	// long output stall, fills the pipe
	localparam int WATCHDOG_LIMIT  = 1000;	// cycles with no transfer on either side
	localparam int DRAIN_TAIL      = 6;	// extra edges waited after the drain before the final check

	// Expected ALU outcomes, oldest first, plus the mismatch bookkeeping.
	class alu_scoreboard;
		alu_res_t    alu_outcomes[$];
		int unsigned mismatches;
		int unsigned checked;

		// Bit-accurate ALU behavior for one item.
		function alu_res_t compute_alu(logic [OP_W-1:0] op, logic [WORD_W-1:0] a16,
				logic [WORD_W-1:0] b16, logic [FLAG_W-1:0] fin);
			alu_res_t          r;
			logic [7:0]        a;
			logic [7:0]        b;
			logic              cin;
			logic [8:0]        sum9;
			logic [4:0]        nib;
			logic [12:0]       sum13;
			logic [16:0]       sum17;
			a   = a16[7:0];
			b   = b16[7:0];
			cin = fin[FLAG_C];
			r.result = '0;
			r.flags  = fin;
			r.writes = 1'b1;
			case (op)
				OP_ADD, OP_ADC: begin
					if (op == OP_ADD)
						cin = 1'b0;
					sum9 = a + b + cin;
					nib  = a[3:0] + b[3:0] + cin;
					r.result = {8'h00, sum9[7:0]};
					r.flags = '0;
					r.flags[FLAG_Z] = (sum9[7:0] == 8'h00);
					r.flags[FLAG_H] = nib[4];
					r.flags[FLAG_C] = sum9[8];
				end
				OP_SUB, OP_SBC, OP_CP: begin
					if (op != OP_SBC)
						cin = 1'b0;
					// bit 8 / bit 4 of the widened difference is the borrow
					sum9 = {1'b0, a} - {1'b0, b} - cin;
					nib  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - cin;
					r.flags = '0;
					r.flags[FLAG_Z] = (sum9[7:0] == 8'h00);
					r.flags[FLAG_N] = 1'b1;
					r.flags[FLAG_H] = nib[4];
					r.flags[FLAG_C] = sum9[8];
					if (op == OP_CP)
						r.writes = 1'b0;
					else
						r.result = {8'h00, sum9[7:0]};
				end
				OP_AND, OP_XOR, OP_OR: begin
					if (op == OP_AND)
						sum9[7:0] = a & b;
					else if (op == OP_XOR)
						sum9[7:0] = a ^ b;
					else
						sum9[7:0] = a | b;
					r.result = {8'h00, sum9[7:0]};
					r.flags = '0;
					r.flags[FLAG_Z] = (sum9[7:0] == 8'h00);
					r.flags[FLAG_H] = (op == OP_AND);
				end
				OP_INC8, OP_DEC8: begin
					sum9[7:0] = (op == OP_INC8) ? a + 8'd1 : a - 8'd1;
					r.result = {8'h00, sum9[7:0]};
					r.flags[FLAG_Z] = (sum9[7:0] == 8'h00);
					r.flags[FLAG_N] = (op == OP_DEC8);
					r.flags[FLAG_H] = (op == OP_INC8) ? (a[3:0] == 4'hF) : (a[3:0] == 4'h0);
				end
				OP_INC16: r.result = a16 + 16'd1;
				OP_DEC16: r.result = a16 - 16'd1;
				OP_ADD16: begin
					sum17 = a16 + b16;
					sum13 = a16[11:0] + b16[11:0];
					r.result = sum17[15:0];
					r.flags[FLAG_N] = 1'b0;
					r.flags[FLAG_H] = sum13[12];
					r.flags[FLAG_C] = sum17[16];
				end
				OP_SPE8: begin
					nib  = a16[3:0] + b[3:0];
					sum9 = a16[7:0] + b;
					r.result = a16 + {{8{b[7]}}, b};
					r.flags = '0;
					r.flags[FLAG_H] = nib[4];
					r.flags[FLAG_C] = sum9[8];
				end
				default: begin
					r.flags  = fin;
					r.writes = 1'b0;
				end
			endcase
			return r;
		endfunction

		function void note_operation(logic [OP_W-1:0] op, logic [WORD_W-1:0] a16,
				logic [WORD_W-1:0] b16, logic [FLAG_W-1:0] fin);
			alu_outcomes.push_back(compute_alu(op, a16, b16, fin));
		endfunction

		function void flag_mismatch(string what, logic [WORD_W-1:0] exp_v,
				logic [WORD_W-1:0] got_v);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch: expected %h, got %h", $realtime, what, exp_v, got_v);
		endfunction

		function void check_outcome(alu_res_t got);
			alu_res_t exp_r;
			checked++;
			if (alu_outcomes.size() == 0) begin
				flag_mismatch("unexpected result", '0, got.result);
				return;
			end
			exp_r = alu_outcomes.pop_front();
			if (got.result !== exp_r.result)
				flag_mismatch("result", exp_r.result, got.result);
			if (got.flags !== exp_r.flags)
				flag_mismatch("flags_out", {12'h000, exp_r.flags}, {12'h000, got.flags});
			if (got.writes !== exp_r.writes)
				flag_mismatch("writes_result", {15'h0000, exp_r.writes},
					{15'h0000, got.writes});
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [OP_W-1:0]     operation;
	logic [WORD_W-1:0]   operand_a;
	logic [WORD_W-1:0]   operand_b;
	logic [FLAG_W-1:0]   flags_in;
	logic                out_valid;
	logic                out_ready;
	logic [WORD_W-1:0]   result;
	logic [FLAG_W-1:0]   flags_out;
	logic                writes_result;

	alu_scoreboard       sb;
	int unsigned         items_sent;
	int unsigned         idle_cycles;
	bit [15:0]           ops_seen;
	bit                  hold_off_req;

	eight_bit_cpu_alu_with_flags u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.operand_a     (operand_a),
		.operand_b     (operand_b),
		.flags_in      (flags_in),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result        (result),
		.flags_out     (flags_out),
		.writes_result (writes_result)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Present one item at the falling edge and hold it until the block takes it.
	// Back-to-back calls keep in_valid high with a single assignment per edge.
	task automatic send_item(logic [OP_W-1:0] op, logic [WORD_W-1:0] a16,
			logic [WORD_W-1:0] b16, logic [FLAG_W-1:0] fin);
		@(negedge clk);
		in_valid  <= 1'b1;
		operation <= op;
		operand_a <= a16;
		operand_b <= b16;
		flags_in  <= fin;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_operation(op, a16, b16, fin);
		items_sent++;
		ops_seen[op] = 1'b1;
	endtask

	task automatic idle_input(int unsigned cycles);
		repeat (cycles) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	// Drop valid and wait for every outstanding result to come back.
	task automatic wait_for_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.alu_outcomes.size() != 0)
			@(posedge clk);
	endtask

	// Operand biased toward carry and borrow edges: all zeros, all ones,
	// nibble and byte boundaries, sign bit of the low byte.
	function automatic logic [WORD_W-1:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return {8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)), 4'hF};
			3: return {8'($urandom_range(0, 255)), 8'h80};
			4: return {4'($urandom_range(0, 15)), 12'hFFF};
			5: return 16'($urandom_range(0, 15));
			default: return 16'($urandom);
		endcase
	endfunction

	// Result side: checked on every rising edge where a result moves.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_outcome('{result: result, flags: flags_out, writes: writes_result});
	end

	// Watchdog: give up when neither side has moved for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout after %0d idle cycles", idle_cycles);
			$display("eight_bit_cpu_alu_with_flags_tb NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Receiver: cycles through phases of always-ready, random stalls and a
	// rotating stall pattern; on request it holds off for a long stretch.
	initial begin : receiver
		int       mode;
		int       mode_left;
		bit [7:0] ready_pat;
		mode      = 0;
		mode_left = 0;
		ready_pat = '1;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 2);
					mode_left = $urandom_range(16, 64);
					ready_pat = 8'($urandom_range(1, 255));
				end
				mode_left--;
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 9) < 7);
					default: begin
						out_ready <= ready_pat[0];
						ready_pat = {ready_pat[0], ready_pat[7:1]};
					end
				endcase
			end
		end
	end

	// Sender: directed corners, a full drain pause, then random bursts.
	initial begin : sender
		int unsigned burst;
		int unsigned random_sent;
		bit          hold_done;
		sb           = new();
		items_sent   = 0;
		ops_seen     = '0;
		hold_off_req = 1'b0;
		random_sent  = 0;
		hold_done    = 1'b0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		operation    = '0;
		operand_a    = '0;
		operand_b    = '0;
		flags_in     = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// add / adc: zero, half and full carry, carry in
		send_item(OP_ADD,   16'h0000, 16'h0000, 4'hF);
		send_item(OP_ADD,   16'hAAFF, 16'h5501, 4'h0);
		send_item(OP_ADC,   16'h000F, 16'h0000, 4'h1);
		send_item(OP_ADC,   16'h00FF, 16'hFFFF, 4'hF);
		// sub / sbc: half borrow, full borrow, borrow in
		send_item(OP_SUB,   16'h0010, 16'h0001, 4'h0);
		send_item(OP_SUB,   16'hFF00, 16'h0001, 4'h0);
		send_item(OP_SBC,   16'h0000, 16'h0000, 4'h1);
		send_item(OP_SBC,   16'h0005, 16'h1205, 4'h0);
		// logic ops
		send_item(OP_AND,   16'h00F0, 16'h000F, 4'h0);
		send_item(OP_XOR,   16'h34FF, 16'h00FF, 4'hF);
		send_item(OP_OR,    16'h0000, 16'hFF00, 4'h5);
		send_item(OP_OR,    16'h00A5, 16'h005A, 4'hA);
		// compare: no write-back, result reads zero
		send_item(OP_CP,    16'h0042, 16'h0042, 4'h0);
		// inc8 / dec8: nibble wrap, byte wrap, carry kept
		send_item(OP_INC8,  16'h12FF, 16'h0000, 4'h1);
		send_item(OP_INC8,  16'h000F, 16'h0000, 4'h0);
		send_item(OP_DEC8,  16'h0000, 16'h0000, 4'h1);
		send_item(OP_DEC8,  16'h0001, 16'h0000, 4'h0);
		// 16-bit inc/dec wrap with flags passed through
		send_item(OP_INC16, 16'hFFFF, 16'h0000, 4'hF);
		send_item(OP_DEC16, 16'h0000, 16'h0000, 4'hA);
		// add16: bit-11 carry, bit-15 carry, Z kept
		send_item(OP_ADD16, 16'h0FFF, 16'h0001, 4'h8);
		send_item(OP_ADD16, 16'hFFFF, 16'h0001, 4'h7);
		// sp+e8: most negative offset, low-nibble and low-byte carries
		send_item(OP_SPE8,  16'hFFF8, 16'hFF80, 4'hF);
		send_item(OP_SPE8,  16'h00FF, 16'h0001, 4'hF);
		// unused codes pass flags through and do not write
		send_item(4'd14,    16'h1234, 16'h5678, 4'hA);
		send_item(4'd15,    16'hFFFF, 16'hFFFF, 4'h5);

		// sender pauses until every expected result is back
		wait_for_drain();

		while (random_sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 24);
			// once, partway in: stall the receiver and keep offering items
			if (!hold_done && random_sent >= RANDOM_ITEMS / 3) begin
				hold_done    = 1'b1;
				hold_off_req = 1'b1;
				burst        = 30;
			end
			repeat (burst) begin
				send_item(4'($urandom_range(0, 15)), pick_operand(), pick_operand(),
					4'($urandom_range(0, 15)));
				random_sent++;
			end
			// zero gap keeps some bursts glued together
			if ($urandom_range(0, 3) != 0)
				idle_input($urandom_range(1, 8));
		end

		wait_for_drain();
		repeat (DRAIN_TAIL) @(posedge clk);

		if (sb.alu_outcomes.size() != 0) begin
			$display("%0d results never arrived", sb.alu_outcomes.size());
			sb.mismatches += sb.alu_outcomes.size();
		end
		$display("covered %0d items over %0d of 16 operation codes, %0d results checked",
			items_sent, $countones(ops_seen), sb.checked);
		$display("included a long output stall with input backpressure and a full drain pause");
		if (sb.mismatches == 0) begin
			$display("eight_bit_cpu_alu_with_flags_tb OK");
		end else begin
			$display("%0d mismatches in total", sb.mismatches);
			$display("eight_bit_cpu_alu_with_flags_tb NOT OK");
		end
		$finish;
	end

endmodule
